/* src/rll_pkg.sv */
// Shared types, constants and functions of the resonant ladder low-pass filter.
// Holds the microcode table, fixed-point helpers and coefficient constants.
// No dependencies.
package rll_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int STATE_WIDTH  = 32;
    localparam int FRAC_BITS    = 20;

    localparam int CFG_WIDTH  = 16;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;
    localparam int REG_IDX_LO = 2;

    // magnitude product, rounded signed product, accumulator
    localparam int MAG_W  = 2 * STATE_WIDTH;
    localparam int PROD_W = 2 * STATE_WIDTH - FRAC_BITS + 1;
    localparam int ACC_W  = PROD_W + 2;

    localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;

    localparam logic signed [STATE_WIDTH-1:0] ONE    = STATE_WIDTH'(ONE_L);
    localparam logic signed [STATE_WIDTH-1:0] K116   = STATE_WIDTH'((116 * ONE_L + 50) / 100);
    localparam logic signed [STATE_WIDTH-1:0] K015   = STATE_WIDTH'((15 * ONE_L + 50) / 100);
    localparam logic signed [STATE_WIDTH-1:0] K35013 =
        STATE_WIDTH'((35013 * ONE_L + 50000) / 100000);
    localparam logic signed [STATE_WIDTH-1:0] K03    = STATE_WIDTH'((3 * ONE_L + 5) / 10);
    localparam logic [MAG_W-1:0] HALF = MAG_W'(ONE_L >> 1);

    localparam int R_SCALE_SH = 2;

    localparam logic [CFG_WIDTH-1:0] CUTOFF_RST = 16'hFFFF;
    localparam logic [CFG_WIDTH-1:0] RES_RST    = 16'h8000;

    // normalization by full scale (65535), folded in 16-bit digits
    localparam int CFG_FULL   = 65535;
    localparam int CFG_HALF   = 32767;
    localparam int CONV_W     = FRAC_BITS + CFG_WIDTH + 2;
    localparam int CONV_FOLDS = (CONV_W - 1) / CFG_WIDTH + 1;

    typedef enum logic {
        REG_CUTOFF = 1'b0,
        REG_RES    = 1'b1
    } t_reg_idx;

    typedef enum logic [4:0] {
        SRC_ZERO,
        SRC_X,
        SRC_SI0,
        SRC_SI1,
        SRC_SI2,
        SRC_SI3,
        SRC_SO0,
        SRC_SO1,
        SRC_SO2,
        SRC_SO3,
        SRC_FB,
        SRC_POLE,
        SRC_GAIN,
        SRC_ACC,
        SRC_PROD,
        SRC_FC,
        SRC_R4,
        SRC_ONE,
        SRC_K116,
        SRC_K015,
        SRC_K35013,
        SRC_K03
    } t_src;

    typedef enum logic [2:0] {
        AOP_HOLD,
        AOP_LOAD_P,
        AOP_SRC_SUB_P,
        AOP_SACC_ADD_P,
        AOP_ADD_P
    } t_aop;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_SI0,
        DST_SO0_SI1,
        DST_SO1_SI2,
        DST_SO2_SI3,
        DST_SO3,
        DST_FB,
        DST_POLE,
        DST_GAIN
    } t_dst;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_DISPATCH,
        JMP_OUT,
        JMP_ALWAYS
    } t_jmp;

    localparam int UPC_W = 5;
    localparam logic [UPC_W-1:0] UA_IDLE   = 5'd0;
    localparam logic [UPC_W-1:0] UA_STEP   = 5'd1;
    localparam logic [UPC_W-1:0] UA_DERIVE = 5'd16;

    typedef struct packed {
        logic              mul_en;
        t_src              mul_a;
        t_src              mul_b;
        t_aop              aop;
        t_src              acc_src;
        t_dst              dst;
        logic              out_ld;
        t_jmp              jmp;
        logic [UPC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   x_ld;
    } t_seq_ctl;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic t_uword mk(input logic me, input t_src a, input t_src b,
                                  input t_aop op, input t_src s, input t_dst d,
                                  input logic ol, input t_jmp j,
                                  input logic [UPC_W-1:0] t);
        t_uword w;
        w.mul_en  = me;
        w.mul_a   = a;
        w.mul_b   = b;
        w.aop     = op;
        w.acc_src = s;
        w.dst     = d;
        w.out_ld  = ol;
        w.jmp     = j;
        w.target  = t;
        return w;
    endfunction

    // Program: dispatch, filter step (15 words), coefficient derivation (12 words).
    // The multiplier result is registered in r_mag and then in r_prod before it is visible.
    function automatic t_uword ucode(input logic [UPC_W-1:0] a);
        t_uword w;
        w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO, DST_NONE, 1'b0,
               JMP_ALWAYS, UA_IDLE);
        case (a)
            UA_IDLE: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO, DST_NONE,
                            1'b0, JMP_DISPATCH, UA_IDLE);
            // filter step
            UA_STEP + 5'd0: w = mk(1'b1, SRC_SO3, SRC_FB, AOP_HOLD, SRC_ZERO, DST_NONE,
                                   1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd1: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO, DST_NONE,
                                   1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd2: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_SRC_SUB_P, SRC_X,
                                   DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd3: w = mk(1'b1, SRC_ACC, SRC_GAIN, AOP_HOLD, SRC_ZERO, DST_NONE,
                                   1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd4: w = mk(1'b1, SRC_SI0, SRC_K03, AOP_HOLD, SRC_ZERO, DST_NONE,
                                   1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd5: w = mk(1'b1, SRC_POLE, SRC_SO0, AOP_LOAD_P, SRC_ZERO,
                                   DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd6: w = mk(1'b1, SRC_SI1, SRC_K03, AOP_SACC_ADD_P, SRC_ZERO,
                                   DST_SI0, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd7: w = mk(1'b1, SRC_POLE, SRC_SO1, AOP_ADD_P, SRC_ZERO,
                                   DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd8: w = mk(1'b1, SRC_SI2, SRC_K03, AOP_SACC_ADD_P, SRC_ZERO,
                                   DST_SO0_SI1, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd9: w = mk(1'b1, SRC_POLE, SRC_SO2, AOP_ADD_P, SRC_ZERO,
                                   DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd10: w = mk(1'b1, SRC_SI3, SRC_K03, AOP_SACC_ADD_P, SRC_ZERO,
                                    DST_SO1_SI2, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd11: w = mk(1'b1, SRC_POLE, SRC_SO3, AOP_ADD_P, SRC_ZERO,
                                    DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd12: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_SACC_ADD_P, SRC_ZERO,
                                    DST_SO2_SI3, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd13: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_ADD_P, SRC_ZERO,
                                    DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_STEP + 5'd14: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO,
                                    DST_SO3, 1'b1, JMP_OUT, UA_IDLE);
            // coefficient derivation
            UA_DERIVE + 5'd0: w = mk(1'b1, SRC_FC, SRC_K116, AOP_HOLD, SRC_ZERO,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd1: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd2: w = mk(1'b1, SRC_PROD, SRC_PROD, AOP_SRC_SUB_P, SRC_ONE,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd3: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO,
                                     DST_POLE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd4: w = mk(1'b1, SRC_PROD, SRC_PROD, AOP_LOAD_P, SRC_ZERO,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd5: w = mk(1'b1, SRC_PROD, SRC_K015, AOP_HOLD, SRC_ZERO,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd6: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_LOAD_P, SRC_ZERO,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd7: w = mk(1'b1, SRC_ACC, SRC_K35013, AOP_SRC_SUB_P, SRC_ONE,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd8: w = mk(1'b1, SRC_R4, SRC_ACC, AOP_HOLD, SRC_ZERO,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd9: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_LOAD_P, SRC_ZERO,
                                     DST_NONE, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd10: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_LOAD_P, SRC_ZERO,
                                      DST_GAIN, 1'b0, JMP_NEXT, UA_IDLE);
            UA_DERIVE + 5'd11: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO,
                                      DST_FB, 1'b0, JMP_ALWAYS, UA_IDLE);
            default: w = mk(1'b0, SRC_ZERO, SRC_ZERO, AOP_HOLD, SRC_ZERO, DST_NONE,
                            1'b0, JMP_ALWAYS, UA_IDLE);
        endcase
        return w;
    endfunction

    // round(v * 2^F / 65535)
    function automatic logic signed [STATE_WIDTH-1:0] to_unit(
        input logic [CFG_WIDTH-1:0] v);
        logic [CONV_W-1:0] x;
        logic [CONV_W-1:0] q;
        x = (CONV_W'(v) << FRAC_BITS) + CONV_W'(CFG_HALF);
        q = '0;
        for (int i = 0; i < CONV_FOLDS; i++) begin
            q = q + (x >> CFG_WIDTH);
            x = (x >> CFG_WIDTH) + (x & CONV_W'(CFG_FULL + 1 - 1));
        end
        if (x >= CONV_W'(CFG_FULL)) begin
            q = q + CONV_W'(1);
        end
        return STATE_WIDTH'(q);
    endfunction

    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [ACC_W-1:0] v);
        logic [ACC_W-STATE_WIDTH:0] top;
        top = v[ACC_W-1:STATE_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[STATE_WIDTH-1:0];
        end
        return v[ACC_W-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
                          : {1'b0, {(STATE_WIDTH-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [STATE_WIDTH-1:0] v);
        logic [STATE_WIDTH-SAMPLE_WIDTH:0] top;
        top = v[STATE_WIDTH-1:SAMPLE_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[SAMPLE_WIDTH-1:0];
        end
        return v[STATE_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    endfunction

endpackage

/* src/rll_in_if.sv */
// Input sample channel: valid/ready handshake with one sample per beat.
// Depends on rll_pkg for the sample width.
interface rll_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rll_pkg::SAMPLE_WIDTH-1:0] sample_in;

    modport source(output valid, output sample_in, input ready);
    modport sink(input valid, input sample_in, output ready);
endinterface

/* src/rll_out_if.sv */
// Output sample channel: valid/ready handshake with one sample per beat.
// Depends on rll_pkg for the sample width.
interface rll_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rll_pkg::SAMPLE_WIDTH-1:0] sample_out;

    modport source(output valid, output sample_out, input ready);
    modport sink(input valid, input sample_out, output ready);
endinterface

/* src/rll_cfg.sv */
// APB register file for cutoff and resonance; normalizes both to Q.F, resonance times 4.
// Depends on rll_pkg.
module rll_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rll_pkg::APB_AW-1:0]           paddr,
    input  logic [rll_pkg::APB_DW-1:0]           pwdata,
    output logic [rll_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready,
    output logic                                 o_wr,
    output logic signed [rll_pkg::STATE_WIDTH-1:0] o_fc,
    output logic signed [rll_pkg::STATE_WIDTH-1:0] o_r4
);

    logic [rll_pkg::CFG_WIDTH-1:0] r_cutoff;
    logic [rll_pkg::CFG_WIDTH-1:0] r_res;
    rll_pkg::t_reg_idx             idx;

    assign idx    = rll_pkg::t_reg_idx'(paddr[rll_pkg::REG_IDX_LO]);
    assign pready = 1'b1;
    assign o_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff <= rll_pkg::CUTOFF_RST;
            r_res    <= rll_pkg::RES_RST;
        end else if (o_wr) begin
            case (idx)
                rll_pkg::REG_CUTOFF: r_cutoff <= pwdata[rll_pkg::CFG_WIDTH-1:0];
                rll_pkg::REG_RES:    r_res    <= pwdata[rll_pkg::CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            rll_pkg::REG_CUTOFF: prdata = rll_pkg::APB_DW'(r_cutoff);
            rll_pkg::REG_RES:    prdata = rll_pkg::APB_DW'(r_res);
            default:             prdata = '0;
        endcase
    end

    assign o_fc = rll_pkg::to_unit(r_cutoff);
    assign o_r4 = rll_pkg::to_unit(r_res) <<< rll_pkg::R_SCALE_SH;

endmodule

/* src/rll_useq.sv */
// Microcode sequencer: step counter, dispatch and conditional jumps.
// Reads the control store in rll_pkg; drives rll_dp.
module rll_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rll_pkg::t_dp_stat   i_stat,
    output rll_pkg::t_seq_ctl   o_ctl
);

    logic [rll_pkg::UPC_W-1:0] r_upc;
    logic [rll_pkg::UPC_W-1:0] n_upc;
    logic                      r_pend;
    logic                      n_pend;
    rll_pkg::t_uword           uw;
    logic                      x_ld;

    assign uw = rll_pkg::ucode(r_upc);

    // pending derivation after reset and after any register write
    always_comb begin
        n_upc  = r_upc + rll_pkg::UPC_W'(1);
        n_pend = r_pend;
        x_ld   = 1'b0;
        case (uw.jmp)
            rll_pkg::JMP_NEXT: ;
            rll_pkg::JMP_DISPATCH: begin
                if (r_pend) begin
                    n_upc  = rll_pkg::UA_DERIVE;
                    n_pend = 1'b0;
                end else if (i_in_valid) begin
                    n_upc = rll_pkg::UA_STEP;
                    x_ld  = 1'b1;
                end else begin
                    n_upc = r_upc;
                end
            end
            rll_pkg::JMP_OUT: n_upc = i_stat.out_free ? uw.target : r_upc;
            rll_pkg::JMP_ALWAYS: n_upc = uw.target;
            default: n_upc = rll_pkg::UA_IDLE;
        endcase
        if (i_cfg_wr) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc  <= rll_pkg::UA_IDLE;
            r_pend <= 1'b1;
        end else begin
            r_upc  <= n_upc;
            r_pend <= n_pend;
        end
    end

    assign o_in_ready = (r_upc == rll_pkg::UA_IDLE) && !r_pend;
    assign o_ctl.uw   = uw;
    assign o_ctl.x_ld = x_ld;

endmodule

/* src/rll_dp.sv */
// Datapath: two-stage shared multiplier, accumulator with saturation,
// pole state, coefficients and output register. Depends on rll_pkg.
module rll_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rll_pkg::t_seq_ctl                      i_ctl,
    input  logic signed [rll_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic signed [rll_pkg::STATE_WIDTH-1:0]  i_fc,
    input  logic signed [rll_pkg::STATE_WIDTH-1:0]  i_r4,
    input  logic                                   i_out_ready,
    output rll_pkg::t_dp_stat                      o_stat,
    output logic                                   o_out_valid,
    output logic signed [rll_pkg::SAMPLE_WIDTH-1:0] o_sample
);

    localparam int SW = rll_pkg::STATE_WIDTH;
    localparam int AW = rll_pkg::ACC_W;
    localparam int PW = rll_pkg::PROD_W;
    localparam int MW = rll_pkg::MAG_W;
    localparam int NP = 4;

    logic signed [rll_pkg::SAMPLE_WIDTH-1:0] r_x;
    logic signed [SW-1:0]                    r_si [NP];
    logic signed [SW-1:0]                    r_so [NP];
    logic signed [SW-1:0]                    r_fb;
    logic signed [SW-1:0]                    r_pole;
    logic signed [SW-1:0]                    r_gain;
    logic [MW-1:0]                           r_mag;
    logic                                    r_neg;
    logic                                    r_mv;
    logic signed [PW-1:0]                    r_prod;
    logic signed [AW-1:0]                    r_acc;
    logic signed [AW-1:0]                    n_acc;
    logic                                    r_out_v;
    logic signed [rll_pkg::SAMPLE_WIDTH-1:0] r_out;

    logic signed [SW-1:0] op_a;
    logic signed [SW-1:0] op_b;
    logic signed [SW-1:0] op_s;
    logic signed [SW-1:0] sacc;
    logic signed [SW-1:0] sprod;
    logic [SW-1:0]        mag_a;
    logic [SW-1:0]        mag_b;
    logic [MW-1:0]        rnd;
    logic signed [PW-1:0] pmag;
    logic                 out_free;
    rll_pkg::t_uword      uw;

    assign uw    = i_ctl.uw;
    assign sacc  = rll_pkg::sat_state(r_acc);
    assign sprod = rll_pkg::sat_state(AW'(r_prod));

    function automatic logic signed [SW-1:0] pick(input rll_pkg::t_src s);
        case (s)
            rll_pkg::SRC_ZERO:   return '0;
            rll_pkg::SRC_X:      return SW'(r_x);
            rll_pkg::SRC_SI0:    return r_si[0];
            rll_pkg::SRC_SI1:    return r_si[1];
            rll_pkg::SRC_SI2:    return r_si[2];
            rll_pkg::SRC_SI3:    return r_si[3];
            rll_pkg::SRC_SO0:    return r_so[0];
            rll_pkg::SRC_SO1:    return r_so[1];
            rll_pkg::SRC_SO2:    return r_so[2];
            rll_pkg::SRC_SO3:    return r_so[3];
            rll_pkg::SRC_FB:     return r_fb;
            rll_pkg::SRC_POLE:   return r_pole;
            rll_pkg::SRC_GAIN:   return r_gain;
            rll_pkg::SRC_ACC:    return sacc;
            rll_pkg::SRC_PROD:   return sprod;
            rll_pkg::SRC_FC:     return i_fc;
            rll_pkg::SRC_R4:     return i_r4;
            rll_pkg::SRC_ONE:    return rll_pkg::ONE;
            rll_pkg::SRC_K116:   return rll_pkg::K116;
            rll_pkg::SRC_K015:   return rll_pkg::K015;
            rll_pkg::SRC_K35013: return rll_pkg::K35013;
            rll_pkg::SRC_K03:    return rll_pkg::K03;
            default:             return '0;
        endcase
    endfunction

    always_comb begin
        op_a = pick(uw.mul_a);
        op_b = pick(uw.mul_b);
        op_s = pick(uw.acc_src);
    end

    // sign-magnitude multiply, round half away from zero
    assign mag_a = op_a[SW-1] ? SW'(-op_a) : SW'(op_a);
    assign mag_b = op_b[SW-1] ? SW'(-op_b) : SW'(op_b);
    assign rnd   = (r_mag + rll_pkg::HALF) >> rll_pkg::FRAC_BITS;
    assign pmag  = rnd[PW-1:0];

    always_comb begin
        case (uw.aop)
            rll_pkg::AOP_HOLD:       n_acc = r_acc;
            rll_pkg::AOP_LOAD_P:     n_acc = AW'(r_prod);
            rll_pkg::AOP_SRC_SUB_P:  n_acc = AW'(op_s) - AW'(r_prod);
            rll_pkg::AOP_SACC_ADD_P: n_acc = AW'(sacc) + AW'(r_prod);
            rll_pkg::AOP_ADD_P:      n_acc = r_acc + AW'(r_prod);
            default:                 n_acc = r_acc;
        endcase
    end

    assign out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv    <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k < NP; k++) begin
                r_si[k] <= '0;
                r_so[k] <= '0;
            end
        end else begin
            r_mv <= uw.mul_en;
            if (uw.out_ld && out_free) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            case (uw.dst)
                rll_pkg::DST_SI0: r_si[0] <= sacc;
                rll_pkg::DST_SO0_SI1: begin
                    r_so[0] <= sacc;
                    r_si[1] <= sacc;
                end
                rll_pkg::DST_SO1_SI2: begin
                    r_so[1] <= sacc;
                    r_si[2] <= sacc;
                end
                rll_pkg::DST_SO2_SI3: begin
                    r_so[2] <= sacc;
                    r_si[3] <= sacc;
                end
                rll_pkg::DST_SO3: r_so[3] <= sacc;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.x_ld) begin
            r_x <= i_sample;
        end
        if (uw.mul_en) begin
            r_mag <= MW'(mag_a) * MW'(mag_b);
            r_neg <= op_a[SW-1] ^ op_b[SW-1];
        end
        if (r_mv) begin
            r_prod <= r_neg ? -pmag : pmag;
        end
        r_acc <= n_acc;
        case (uw.dst)
            rll_pkg::DST_FB:   r_fb   <= sacc;
            rll_pkg::DST_POLE: r_pole <= sacc;
            rll_pkg::DST_GAIN: r_gain <= sacc;
            default: ;
        endcase
        if (uw.out_ld && out_free) begin
            r_out <= rll_pkg::sat_sample(sacc);
        end
    end

    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_v;
    assign o_sample        = r_out;

endmodule

/* src/resonant_ladder_lowpass.sv */
// Four-pole resonant ladder low-pass filter, microcoded around one multiplier.
// Depends on rll_pkg, rll_in_if, rll_out_if, rll_cfg, rll_useq, rll_dp.
//
//   port        dir   beat                   width
//   i_smp       in    sample_in, Q3.20       24
//   o_smp       out   sample_out, Q3.20      24
//   APB         in    cutoff @0, resonance @4  16 of 32
//
// Each sample runs a dispatch step plus 15 program steps, set by the single
// shared multiplier and its two pipeline stages.
// After reset and after each register write a 12-step derivation program runs
// before the next input beat is taken.
// The result sits in an output register; while it is not taken, the last
// program step holds and no new beat is accepted.
module resonant_ladder_lowpass (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rll_in_if.sink                      i_smp,
    rll_out_if.source                   o_smp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rll_pkg::APB_AW-1:0]  paddr,
    input  logic [rll_pkg::APB_DW-1:0]  pwdata,
    output logic [rll_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic                                  cfg_wr;
    logic signed [rll_pkg::STATE_WIDTH-1:0] fc;
    logic signed [rll_pkg::STATE_WIDTH-1:0] r4;
    rll_pkg::t_seq_ctl                     ctl;
    rll_pkg::t_dp_stat                     stat;

    rll_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_wr    (cfg_wr),
        .o_fc    (fc),
        .o_r4    (r4)
    );

    rll_useq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (cfg_wr),
        .i_in_valid (i_smp.valid),
        .o_in_ready (i_smp.ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    rll_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_sample    (i_smp.sample_in),
        .i_fc        (fc),
        .i_r4        (r4),
        .i_out_ready (o_smp.ready),
        .o_stat      (stat),
        .o_out_valid (o_smp.valid),
        .o_sample    (o_smp.sample_out)
    );

endmodule
